[sv/urbc_pkg.sv]
// ----------------------------------------------------------------------------
// urbc_pkg
// Shared widths, event and status codes, and ring pointer helpers for the
// UART ring buffer controller.
// ----------------------------------------------------------------------------
`default_nettype none

package urbc_pkg;

  localparam int DATA_W        = 8;
  localparam int PTR_W         = 8;
  localparam int SIZE_W        = 8;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 3;
  localparam int RING_DEPTH_DEF = 256;

  // Event kinds
  localparam logic [MODE_W-1:0] MODE_RECV    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TX_DONE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP     = 2'd3;

  // Result codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TX_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RX_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RX_DROP  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SPURIOUS = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_SIZE = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd255;

  // Size in use: zero acts as one, anything above the memory depth is capped.
  function automatic logic [SIZE_W:0] eff_size(input logic [SIZE_W-1:0] s,
                                               input logic [SIZE_W:0]   depth);
    logic [SIZE_W:0] e;
    e = {1'b0, s};
    if (s == '0) begin
      e = 9'd1;
    end else if (e > depth) begin
      e = depth;
    end
    return e;
  endfunction

  // Step a pointer, wrapping to zero at the size in use.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0]  p,
                                               input logic [SIZE_W-1:0] s,
                                               input logic [SIZE_W:0]   depth);
    logic [PTR_W-1:0] n;
    logic [SIZE_W:0]  e;
    n = p + 8'd1;
    e = eff_size(s, depth);
    return ({1'b0, n} >= e) ? '0 : n;
  endfunction

  // Bytes waiting in a ring, modulo 256.
  function automatic logic [PTR_W-1:0] ring_count(input logic              empty,
                                                  input logic [PTR_W-1:0]  r,
                                                  input logic [PTR_W-1:0]  w,
                                                  input logic [SIZE_W-1:0] s,
                                                  input logic [SIZE_W:0]   depth);
    logic [SIZE_W:0] sum;
    logic [PTR_W-1:0] cnt;
    sum = eff_size(s, depth) - {1'b0, r} + {1'b0, w};
    if (empty) begin
      cnt = '0;
    end else if (r < w) begin
      cnt = w - r;
    end else begin
      cnt = sum[PTR_W-1:0];
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

[sv/urbc_ring_mem.sv]
// ----------------------------------------------------------------------------
// urbc_ring_mem
// Ring storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module urbc_ring_mem #(
  parameter int RING_DEPTH = urbc_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(RING_DEPTH)-1:0] wr_addr,
  input  wire logic [urbc_pkg::DATA_W-1:0]   wr_data,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(RING_DEPTH)-1:0] rd_addr,
  output logic      [urbc_pkg::DATA_W-1:0]   rd_data
);

  logic [urbc_pkg::DATA_W-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/uart_ring_buffer_controller_unit.sv]
// ----------------------------------------------------------------------------
// uart_ring_buffer_controller_unit
// Buffered UART controller: transmit and receive byte rings with host access.
// ----------------------------------------------------------------------------
// Each input transaction is one event: a byte received from the line, a
// transmit-done from the serializer, a host push or a host pop. Each event
// gives exactly one result transaction with a status code, the popped byte,
// the transmitter load strobe and byte, the receiver enable, the receive
// fill count and the four ring flags. The accept edge captures the event
// and starts the registered ring memory reads; the commit edge makes the
// pointer and flag update, writes the ring and fills the output register.
// A new event is taken from the cycle after the commit on, never while one
// is in flight; the output register frees the input side while a result
// waits, and a stalled output holds the commit back. Since reads of an event
// are issued only after the previous event has written its ring, no
// forwarding is needed. Ring sizes are written through the cfg channel; the
// user must write them only while no event is in flight; nothing checks it.
// A size of 0 acts as 1, a size above RING_DEPTH acts as RING_DEPTH.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_ring_buffer_controller_unit #(
  parameter int RING_DEPTH = urbc_pkg::RING_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // event input
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,  // [7:0] data_in
  input  wire logic [1:0]                      s_tuser,  // [1:0] mode
  // result output
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [2:0] status, [10:3] read_data, [11] tx_load, [19:12] tx_data,
  // [20] rx_enable, [28:21] recv_count, [29] send_full_flag,
  // [30] send_empty_flag, [31] recv_empty_flag, [32] recv_full_flag, rest 0
  output logic [39:0]                          m_tdata,
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [urbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [urbc_pkg::SIZE_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [urbc_pkg::SIZE_W:0] DEPTH_V = 9'(RING_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  localparam int PW = urbc_pkg::PTR_W;
  localparam int DW = urbc_pkg::DATA_W;

  // control state
  logic state;
  logic [PW-1:0] tx_read_ptr, tx_write_ptr, rx_read_ptr, rx_write_ptr;
  logic tx_full, tx_empty, rx_full, rx_empty, rx_enabled;
  logic [urbc_pkg::SIZE_W-1:0] send_size, recv_size;

  // captured event
  logic [urbc_pkg::MODE_W-1:0] mode_q;
  logic [DW-1:0]               data_q;

  // next values computed in the commit cycle
  logic [PW-1:0] tx_read_ptr_next, tx_write_ptr_next;
  logic [PW-1:0] rx_read_ptr_next, rx_write_ptr_next;
  logic tx_full_next, tx_empty_next, rx_full_next, rx_empty_next, rx_enabled_next;
  logic [urbc_pkg::STATUS_W-1:0] status_next;
  logic [DW-1:0] rdata_next, tdata_next;
  logic          load_next;
  logic          tx_we, rx_we;
  logic [PW-1:0] recv_count_next;

  logic accept, commit;
  logic [PW-1:0]  tx_adv_rd, tx_adv_wr, rx_adv_rd, rx_adv_wr;
  logic [DW-1:0]  tx_rdata, rx_rdata;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign commit    = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign cfg_ready = 1'b1;

  assign tx_adv_rd = urbc_pkg::advance(tx_read_ptr, send_size, DEPTH_V);
  assign tx_adv_wr = urbc_pkg::advance(tx_write_ptr, send_size, DEPTH_V);
  assign rx_adv_rd = urbc_pkg::advance(rx_read_ptr, recv_size, DEPTH_V);
  assign rx_adv_wr = urbc_pkg::advance(rx_write_ptr, recv_size, DEPTH_V);

  // Transmit ring: read ahead at the next read slot for transmit-done.
  urbc_ring_mem #(.RING_DEPTH(RING_DEPTH)) u_tx_mem (
    .clk     (clk),
    .wr_en   (tx_we),
    .wr_addr (tx_write_ptr[IDX_W-1:0]),
    .wr_data (data_q),
    .rd_en   (accept),
    .rd_addr (tx_adv_rd[IDX_W-1:0]),
    .rd_data (tx_rdata)
  );

  // Receive ring: read at the current read slot for a host pop.
  urbc_ring_mem #(.RING_DEPTH(RING_DEPTH)) u_rx_mem (
    .clk     (clk),
    .wr_en   (rx_we),
    .wr_addr (rx_write_ptr[IDX_W-1:0]),
    .wr_data (data_q),
    .rd_en   (accept),
    .rd_addr (rx_read_ptr[IDX_W-1:0]),
    .rd_data (rx_rdata)
  );

  // Event update
  always_comb begin
    tx_read_ptr_next  = tx_read_ptr;
    tx_write_ptr_next = tx_write_ptr;
    rx_read_ptr_next  = rx_read_ptr;
    rx_write_ptr_next = rx_write_ptr;
    tx_full_next      = tx_full;
    tx_empty_next     = tx_empty;
    rx_full_next      = rx_full;
    rx_empty_next     = rx_empty;
    rx_enabled_next   = rx_enabled;
    status_next       = urbc_pkg::ST_OK;
    rdata_next        = '0;
    tdata_next        = '0;
    load_next         = 1'b0;
    tx_we             = 1'b0;
    rx_we             = 1'b0;
    case (mode_q)
      urbc_pkg::MODE_RECV: begin
        if (rx_full) begin
          rx_enabled_next = 1'b0;
          status_next     = urbc_pkg::ST_RX_DROP;
        end else begin
          rx_we             = commit;
          rx_write_ptr_next = rx_adv_wr;
          rx_empty_next     = 1'b0;
          rx_full_next      = (rx_adv_wr == rx_read_ptr);
        end
      end
      urbc_pkg::MODE_TX_DONE: begin
        if (tx_empty) begin
          status_next = urbc_pkg::ST_SPURIOUS;
        end else begin
          tx_read_ptr_next = tx_adv_rd;
          tx_full_next     = 1'b0;
          if (tx_adv_rd == tx_write_ptr) begin
            tx_empty_next = 1'b1;
          end else begin
            load_next  = 1'b1;
            tdata_next = tx_rdata;
          end
        end
      end
      urbc_pkg::MODE_PUSH: begin
        if (tx_full) begin
          status_next = urbc_pkg::ST_TX_FULL;
        end else begin
          tx_we             = commit;
          tx_write_ptr_next = tx_adv_wr;
          // idle transmitter takes the byte straight away
          if (tx_empty) begin
            load_next  = 1'b1;
            tdata_next = data_q;
          end
          tx_empty_next = 1'b0;
          tx_full_next  = (tx_adv_wr == tx_read_ptr);
        end
      end
      default: begin
        if (rx_empty) begin
          rx_enabled_next = 1'b1;
          status_next     = urbc_pkg::ST_RX_EMPTY;
        end else begin
          rdata_next       = rx_rdata;
          rx_read_ptr_next = rx_adv_rd;
          rx_full_next     = 1'b0;
          rx_empty_next    = (rx_adv_rd == rx_write_ptr);
        end
      end
    endcase
    recv_count_next = urbc_pkg::ring_count(rx_empty_next, rx_read_ptr_next,
                                           rx_write_ptr_next, recv_size, DEPTH_V);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tx_read_ptr  <= '0;
      tx_write_ptr <= '0;
      rx_read_ptr  <= '0;
      rx_write_ptr <= '0;
      tx_full      <= 1'b0;
      tx_empty     <= 1'b1;
      rx_full      <= 1'b0;
      rx_empty     <= 1'b1;
      rx_enabled   <= 1'b0;
      send_size    <= urbc_pkg::SIZE_RESET;
      recv_size    <= urbc_pkg::SIZE_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          urbc_pkg::CFG_SEND_SIZE: send_size <= cfg_data;
          urbc_pkg::CFG_RECV_SIZE: recv_size <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        state <= ST_EXEC;
      end else if (commit) begin
        state        <= ST_IDLE;
        tx_read_ptr  <= tx_read_ptr_next;
        tx_write_ptr <= tx_write_ptr_next;
        rx_read_ptr  <= rx_read_ptr_next;
        rx_write_ptr <= rx_write_ptr_next;
        tx_full      <= tx_full_next;
        tx_empty     <= tx_empty_next;
        rx_full      <= rx_full_next;
        rx_empty     <= rx_empty_next;
        rx_enabled   <= rx_enabled_next;
      end
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= s_tuser;
      data_q <= s_tdata;
    end
    if (commit) begin
      m_tdata <= {7'd0, rx_full_next, rx_empty_next, tx_empty_next, tx_full_next,
                  recv_count_next, rx_enabled_next, tdata_next, load_next,
                  rdata_next, status_next};
    end
  end

  // Assertions
  a_tx_flags: assert property (@(posedge clk) disable iff (rst)
    !(tx_full && tx_empty))
    else $error("transmit ring both full and empty");

  a_rx_flags: assert property (@(posedge clk) disable iff (rst)
    !(rx_full && rx_empty))
    else $error("receive ring both full and empty");

  a_rx_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    rx_empty |-> (rx_read_ptr == rx_write_ptr))
    else $error("receive ring empty with pointers apart");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC) && !s_tready)
    else $error("accepted event not held for commit");

  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid && (state == ST_IDLE))
    else $error("commit did not present a result");

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UART ring buffer controller: a scoreboard class
// predicts every result from its own copy of both rings, and plain tasks
// drive events and size writes with random idling and output stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
  localparam int HOLD_CYCLES    = 120;   // long output stall, fills the pipe
  localparam int IDLE_PCT       = 22;    // idle cycles per hundred, each side
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 26;

  // Result transaction as packed on m_tdata, MSB first.
  typedef struct packed {
    logic [6:0] pad;
    logic       rx_is_full;
    logic       rx_is_empty;
    logic       tx_is_empty;
    logic       tx_is_full;
    logic [7:0] recv_count;
    logic       rx_enable;
    logic [7:0] tx_data;
    logic       tx_load;
    logic [7:0] read_data;
    logic [2:0] status;
  } uart_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: ring state copy, expected results queue, field compare.
  // --------------------------------------------------------------------------
  class uart_ring_scoreboard;
    logic [7:0]   tx_mem [256];
    logic [7:0]   rx_mem [256];
    logic [7:0]   tx_rd, tx_wr, rx_rd, rx_wr;
    bit           tx_full, tx_empty, rx_full, rx_empty, rx_on;
    logic [7:0]   send_size, recv_size;
    uart_result_t awaited [$];
    int           errors, events, results;
    int           status_hits [5];

    function new();
      foreach (tx_mem[i]) begin
        tx_mem[i] = '0;
        rx_mem[i] = '0;
      end
      tx_rd = '0; tx_wr = '0; rx_rd = '0; rx_wr = '0;
      tx_full = 0; tx_empty = 1; rx_full = 0; rx_empty = 1; rx_on = 0;
      send_size = urbc_pkg::SIZE_RESET;
      recv_size = urbc_pkg::SIZE_RESET;
      errors = 0; events = 0; results = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void set_size(logic [urbc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == urbc_pkg::CFG_SEND_SIZE) send_size = val;
      else recv_size = val;
    endfunction

    // 8-bit size can never exceed the 256-entry store, so only zero is special.
    function int unsigned span_of(logic [7:0] s);
      return (s == 8'd0) ? 1 : s;
    endfunction

    function logic [7:0] next_slot(logic [7:0] p, logic [7:0] s);
      int unsigned n;
      n = (p + 1) % 256;
      return (n >= span_of(s)) ? 8'd0 : n[7:0];
    endfunction

    // Fill level wraps mod 256 when pointers sit beyond a shrunken size.
    function logic [7:0] rx_level();
      int unsigned t;
      if (rx_empty) return 8'd0;
      if (rx_rd < rx_wr) return rx_wr - rx_rd;
      t = span_of(recv_size) - rx_rd + rx_wr;
      return t[7:0];
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_event(logic [1:0] mode, logic [7:0] data);
      uart_result_t r;
      r = '0;
      r.status = urbc_pkg::ST_OK;
      case (mode)
        urbc_pkg::MODE_RECV: begin
          if (rx_full) begin
            rx_on = 0;
            r.status = urbc_pkg::ST_RX_DROP;
          end else begin
            rx_mem[rx_wr] = data;
            rx_wr = next_slot(rx_wr, recv_size);
            rx_empty = 0;
            if (rx_wr == rx_rd) rx_full = 1;
          end
        end
        urbc_pkg::MODE_TX_DONE: begin
          if (tx_empty) begin
            r.status = urbc_pkg::ST_SPURIOUS;
          end else begin
            tx_rd = next_slot(tx_rd, send_size);
            tx_full = 0;
            if (tx_rd == tx_wr) begin
              tx_empty = 1;
            end else begin
              r.tx_load = 1'b1;
              r.tx_data = tx_mem[tx_rd];
            end
          end
        end
        urbc_pkg::MODE_PUSH: begin
          if (tx_full) begin
            r.status = urbc_pkg::ST_TX_FULL;
          end else begin
            tx_mem[tx_wr] = data;
            tx_wr = next_slot(tx_wr, send_size);
            if (tx_empty) begin
              r.tx_load = 1'b1;
              r.tx_data = data;
            end
            tx_empty = 0;
            if (tx_wr == tx_rd) tx_full = 1;
          end
        end
        default: begin
          if (rx_empty) begin
            rx_on = 1;
            r.status = urbc_pkg::ST_RX_EMPTY;
          end else begin
            r.read_data = rx_mem[rx_rd];
            rx_rd = next_slot(rx_rd, recv_size);
            rx_full = 0;
            if (rx_rd == rx_wr) rx_empty = 1;
          end
        end
      endcase
      r.rx_enable   = rx_on;
      r.recv_count  = rx_level();
      r.tx_is_full  = tx_full;
      r.tx_is_empty = tx_empty;
      r.rx_is_empty = rx_empty;
      r.rx_is_full  = rx_full;
      awaited.push_back(r);
      events++;
    endfunction

    function void field_diff(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        $display("%0t: result %0d %s mismatch: expected %h, got %h",
                 $time, results, name, want_v, got_v);
      end
    endfunction

    function void check_result(logic [39:0] word);
      uart_result_t got, want;
      got = uart_result_t'(word);
      results++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, got %h",
                 $time, word);
        return;
      end
      want = awaited.pop_front();
      if (want.status <= urbc_pkg::ST_SPURIOUS) status_hits[want.status]++;
      field_diff("status",          8'(want.status),      8'(got.status));
      field_diff("read_data",       want.read_data,       got.read_data);
      field_diff("tx_load",         8'(want.tx_load),     8'(got.tx_load));
      field_diff("tx_data",         want.tx_data,         got.tx_data);
      field_diff("rx_enable",       8'(want.rx_enable),   8'(got.rx_enable));
      field_diff("recv_count",      want.recv_count,      got.recv_count);
      field_diff("send_full_flag",  8'(want.tx_is_full),  8'(got.tx_is_full));
      field_diff("send_empty_flag", 8'(want.tx_is_empty), 8'(got.tx_is_empty));
      field_diff("recv_empty_flag", 8'(want.rx_is_empty), 8'(got.rx_is_empty));
      field_diff("recv_full_flag",  8'(want.rx_is_full),  8'(got.rx_is_full));
      field_diff("padding",         8'(want.pad),         8'(got.pad));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals. Every input is known from time zero.
  // --------------------------------------------------------------------------
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata = '0;   // [7:0] data_in
  logic [1:0]                     s_tuser = '0;   // [1:0] mode
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [39:0]                    m_tdata;        // result fields, see uart_result_t
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [urbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [urbc_pkg::SIZE_W-1:0]    cfg_data = '0;

  uart_ring_scoreboard sb = new();

  bit steady = 0;          // when set, neither side idles
  int holds_wanted = 0;    // long output stalls requested by the sequence
  int holds_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int settings = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  uart_ring_buffer_controller_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Result side: random ready, plus long hold-offs counted here on request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (holds_done != holds_wanted) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Watchdog: the run is stuck if no channel moves a transaction for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, sb.pending());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Event driver. tvalid is only lowered during a gap, so a back-to-back
  // event never lowers and raises it in the same step.
  // --------------------------------------------------------------------------
  task automatic send_event(input logic [1:0] mode, input logic [7:0] data);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_event(mode, data);
  endtask

  // Sender goes quiet until every expected result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes both ring sizes; valid stays high across the two transactions.
  task automatic set_sizes(input logic [7:0] send_sz, input logic [7:0] recv_sz);
    cfg_valid <= 1'b1;
    cfg_index <= urbc_pkg::CFG_SEND_SIZE;
    cfg_data  <= send_sz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_size(urbc_pkg::CFG_SEND_SIZE, send_sz);
    cfg_index <= urbc_pkg::CFG_RECV_SIZE;
    cfg_data  <= recv_sz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_size(urbc_pkg::CFG_RECV_SIZE, recv_sz);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // One random event; the fill percentages steer each ring toward full or empty.
  task automatic random_event(input int rx_fill_pct, input int tx_fill_pct);
    logic [1:0] mode;
    logic [7:0] data;
    if ($urandom_range(1))
      mode = ($urandom_range(99) < rx_fill_pct) ? urbc_pkg::MODE_RECV : urbc_pkg::MODE_POP;
    else
      mode = ($urandom_range(99) < tx_fill_pct) ? urbc_pkg::MODE_PUSH
                                                 : urbc_pkg::MODE_TX_DONE;
    case ($urandom_range(7))
      0:       data = 8'h00;
      1:       data = 8'hFF;
      default: data = 8'($urandom_range(255));
    endcase
    send_event(mode, data);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] send_sz, recv_sz;
    int rx_pct, tx_pct;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: tiny rings (send 2, recv 0 acting as 1) reach every corner fast.
    set_sizes(8'd2, 8'd0);
    send_event(urbc_pkg::MODE_POP,     8'h00);  // pop while empty: enables receiver
    send_event(urbc_pkg::MODE_TX_DONE, 8'hFF);  // transmit done while idle
    send_event(urbc_pkg::MODE_RECV,    8'h00);  // fills the one-entry receive ring
    send_event(urbc_pkg::MODE_RECV,    8'hFF);  // receive while full: dropped, rx off
    send_event(urbc_pkg::MODE_POP,     8'h00);
    send_event(urbc_pkg::MODE_POP,     8'hFF);  // pop while empty again: enables receiver
    send_event(urbc_pkg::MODE_PUSH,    8'h00);  // idle transmitter loads at once
    send_event(urbc_pkg::MODE_PUSH,    8'hFF);  // transmit ring now full
    send_event(urbc_pkg::MODE_PUSH,    8'hAA);  // push while full: refused
    send_event(urbc_pkg::MODE_TX_DONE, 8'h00);  // loads next byte
    send_event(urbc_pkg::MODE_RECV,    8'h55);
    send_event(urbc_pkg::MODE_POP,     8'hAA);
    send_event(urbc_pkg::MODE_TX_DONE, 8'h55);  // transmitter goes idle
    send_event(urbc_pkg::MODE_TX_DONE, 8'h00);
    send_event(urbc_pkg::MODE_PUSH,    8'hFF);
    send_event(urbc_pkg::MODE_TX_DONE, 8'hFF);
    wait_drained();

    // Full-size fill and drain. This writes every store entry in use, so later
    // size changes never make the block read an entry that was never written.
    // The output hold-off lands here while events keep coming; the drain runs
    // as one long stretch with no idling.
    set_sizes(urbc_pkg::SIZE_RESET, urbc_pkg::SIZE_RESET);
    holds_wanted = holds_wanted + 1;
    for (int i = 0; i < 256; i++) begin
      send_event(urbc_pkg::MODE_RECV, 8'($urandom_range(255)));
      send_event(urbc_pkg::MODE_PUSH, 8'($urandom_range(255)));
    end
    steady = 1;
    for (int i = 0; i < 256; i++) begin
      send_event(urbc_pkg::MODE_POP,     8'($urandom_range(255)));
      send_event(urbc_pkg::MODE_TX_DONE, 8'($urandom_range(255)));
    end
    steady = 0;

    // Random phases. Sizes change between phases with data still in the rings.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       begin send_sz = 8'd255; recv_sz = 8'd1;   end
        1:       begin send_sz = 8'd1;   recv_sz = 8'd255; end
        2:       begin send_sz = 8'd0;   recv_sz = 8'd0;   end
        3:       begin send_sz = 8'd2;   recv_sz = 8'd3;   end
        5:       begin send_sz = 8'd255; recv_sz = 8'd255; end
        6:       begin
          send_sz = 8'($urandom_range(255));
          recv_sz = 8'($urandom_range(255));
        end
        7:       begin send_sz = 8'd8;   recv_sz = 8'd5;   end
        9:       begin send_sz = 8'd1;   recv_sz = 8'd1;   end
        default: begin
          send_sz = 8'($urandom_range(1, 16));
          recv_sz = 8'($urandom_range(1, 16));
        end
      endcase
      set_sizes(send_sz, recv_sz);
      steady = (ph == 4);  // a stretch with no idling on either side
      rx_pct = 20 + 30 * $urandom_range(2);
      tx_pct = 20 + 30 * $urandom_range(2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 7 && n == PHASE_ITEMS / 2) wait_drained();
        random_event(rx_pct, tx_pct);
      end
      steady = 0;
    end

    wait_drained();
    repeat (6) @(posedge clk);

    $display("Run covered %0d events and %0d results over %0d size settings,",
             sb.events, sb.results, settings);
    $display("statuses: ok %0d, push refused %0d, pop empty %0d, dropped %0d, spurious %0d",
             sb.status_hits[urbc_pkg::ST_OK], sb.status_hits[urbc_pkg::ST_TX_FULL],
             sb.status_hits[urbc_pkg::ST_RX_EMPTY], sb.status_hits[urbc_pkg::ST_RX_DROP],
             sb.status_hits[urbc_pkg::ST_SPURIOUS]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
